// ===== rtl/dqr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr_pkg
// Shared types, tables and constants of the 8x8 DCT / quantize / RLE encoder.
// ----------------------------------------------------------------------------
package dqr_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned SCALE_W  = 6;
  localparam int unsigned ROW_W    = 18;
  localparam int unsigned DCT_W    = 12;
  localparam int unsigned ACC_W    = 27;
  localparam int unsigned PROD_W   = 26;
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned DIV_W    = 14;
  localparam int unsigned REM_W    = 15;
  localparam int unsigned SCALE_RESET = 5;
  localparam int unsigned LAST_CODED  = 62;
  localparam int unsigned DCT_SHIFT   = 14;

  localparam logic [CODE_W-1:0] END_CODE    = 16'd15;
  localparam logic [CODE_W-1:0] LONG_MARK   = 16'h8000;
  localparam logic [1:0]        ONE_BYTE    = 2'd1;
  localparam logic [1:0]        TWO_BYTES   = 2'd2;

  // Register byte addresses (index times four)
  localparam logic QUANT_SCALE_IDX = 1'b0;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_ROW   = 8'b0000_0010,
    S_COL   = 8'b0000_0100,
    S_QRD   = 8'b0000_1000,
    S_QSET  = 8'b0001_0000,
    S_QDIV  = 8'b0010_0000,
    S_QEMIT = 8'b0100_0000,
    S_END   = 8'b1000_0000
  } state_e;

  // Cosine matrix, indexed {row, column}
  localparam logic signed [7:0] COS_MAT [64] = '{
     8'sd45,  8'sd45,  8'sd45,  8'sd45,  8'sd45,  8'sd45,  8'sd45,  8'sd45,
     8'sd63,  8'sd53,  8'sd35,  8'sd12, -8'sd12, -8'sd35, -8'sd53, -8'sd63,
     8'sd59,  8'sd24, -8'sd24, -8'sd59, -8'sd59, -8'sd24,  8'sd24,  8'sd59,
     8'sd53, -8'sd12, -8'sd63, -8'sd35,  8'sd35,  8'sd63,  8'sd12, -8'sd53,
     8'sd45, -8'sd45, -8'sd45,  8'sd45,  8'sd45, -8'sd45, -8'sd45,  8'sd45,
     8'sd35, -8'sd63,  8'sd12,  8'sd53, -8'sd53, -8'sd12,  8'sd63, -8'sd35,
     8'sd24, -8'sd59,  8'sd59, -8'sd24, -8'sd24,  8'sd59, -8'sd59,  8'sd24,
     8'sd12, -8'sd35,  8'sd53, -8'sd63,  8'sd63, -8'sd53,  8'sd35, -8'sd12
  };

  localparam logic [5:0] ZZ_ORDER [64] = '{
     6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
     6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
     6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
     6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
     6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
     6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
     6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
     6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

  localparam logic [6:0] Q_TABLE [64] = '{
     7'd2,  7'd16, 7'd19, 7'd22, 7'd26, 7'd27, 7'd29, 7'd34,
     7'd16, 7'd16, 7'd22, 7'd24, 7'd27, 7'd29, 7'd34, 7'd37,
     7'd19, 7'd22, 7'd26, 7'd27, 7'd29, 7'd34, 7'd34, 7'd38,
     7'd22, 7'd22, 7'd26, 7'd27, 7'd29, 7'd34, 7'd37, 7'd40,
     7'd22, 7'd26, 7'd27, 7'd29, 7'd32, 7'd35, 7'd40, 7'd48,
     7'd26, 7'd27, 7'd29, 7'd32, 7'd35, 7'd40, 7'd48, 7'd58,
     7'd26, 7'd27, 7'd29, 7'd34, 7'd38, 7'd46, 7'd56, 7'd69,
     7'd27, 7'd29, 7'd35, 7'd38, 7'd46, 7'd56, 7'd69, 7'd83
  };

endpackage

// ===== rtl/dqr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqr channel interfaces
// Valid/ready channels for block samples and for emitted code words.
// ----------------------------------------------------------------------------
interface dqr_in_if;
  import dqr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink (input valid, sample, last_sample, output ready);
endinterface

interface dqr_out_if;
  import dqr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_word;
  logic [1:0]        code_bytes;
  logic              last_code;
  logic [5:0]        symbol_count;
  modport source (output valid, code_word, code_bytes, last_code, symbol_count, input ready);
  modport sink (input valid, code_word, code_bytes, last_code, symbol_count, output ready);
endinterface

// ===== rtl/dct_quant_rle_block_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_quant_rle_block_encoder_core
// 8x8 DCT, zigzag quantizer and run-length coder on one shared multiplier.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while loading; the transaction carrying
// last_sample starts encoding and input stays blocked until the end code is
// issued. One multiplier does the row pass (512 MACs), the column pass
// (512 MACs) and the divisor products; a radix-2 restoring divider then finds
// the 16-bit quotient of each AC coefficient bit by bit. The divider loop sets
// most of the quantizer time. Code words leave through an output register, so
// the next block loads while the end code waits.
module dct_quant_rle_block_encoder_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  dqr_in_if.sink            in_s,
  dqr_out_if.source         out_s,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import dqr_pkg::*;

  // Storage
  logic signed [SAMPLE_W-1:0] smem [64];
  logic signed [ROW_W-1:0]    rmem [64];
  logic signed [DCT_W-1:0]    dmem [64];

  state_e                     state_q, state_d;
  logic [5:0]                 scnt_q, scnt_d;
  logic [9:0]                 cnt_q, cnt_d;
  logic                       pvld_q, pvld_d;
  logic [8:0]                 pidx_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [SAMPLE_W-1:0] sdat_q;
  logic signed [ROW_W-1:0]    rdat_q;
  logic signed [DCT_W-1:0]    ddat_q;
  logic [5:0]                 k_q, k_d;
  logic [5:0]                 run_q, run_d;
  logic [5:0]                 sym_q, sym_d;
  logic [3:0]                 bcnt_q, bcnt_d;
  logic [NUM_W-1:0]           quo_q, quo_d;
  logic [REM_W-1:0]           rem_q, rem_d;
  logic [DIV_W-1:0]           div_q, div_d;
  logic                       neg_q, neg_d;
  logic signed [CODE_W-1:0]   coef_q, coef_d;
  logic [SCALE_W-1:0]         scale_q;
  logic                       ovld_q, ovld_d;
  logic [CODE_W-1:0]          oword_q, oword_d;
  logic [1:0]                 obytes_q, obytes_d;
  logic                       olast_q, olast_d;
  logic [5:0]                 ocount_q, ocount_d;

  logic                       in_acc;
  logic                       can_load;
  logic signed [ROW_W-1:0]    mul_a;
  logic signed [7:0]          mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic [5:0]                 zz_pos;
  logic signed [NUM_W-1:0]    num;
  logic signed [DCT_W-1:0]    dc_val;
  logic [REM_W-1:0]           rem_sh;
  logic [NUM_W-1:0]           quo_nx;
  logic [7:0]                 short_b;
  logic [CODE_W-1:0]          t16;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = {{(32-SCALE_W){1'b0}}, scale_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_W'(SCALE_RESET);
    end else if (psel && penable && pwrite && (paddr[2] == QUANT_SCALE_IDX)) begin
      scale_q <= pwdata[SCALE_W-1:0];
    end
  end

  assign in_s.ready         = (state_q == S_LOAD);
  assign in_acc             = in_s.valid && in_s.ready;
  assign can_load           = !ovld_q || out_s.ready;
  assign out_s.valid        = ovld_q;
  assign out_s.code_word    = oword_q;
  assign out_s.code_bytes   = obytes_q;
  assign out_s.last_code    = olast_q;
  assign out_s.symbol_count = ocount_q;

  assign zz_pos = ZZ_ORDER[k_q];

  // Shared multiplier operand select
  always_comb begin
    mul_a = ROW_W'(sdat_q);
    mul_b = COS_MAT[{pidx_q[5:3], pidx_q[2:0]}];
    case (state_q)
      S_COL: begin
        mul_a = rdat_q;
        mul_b = COS_MAT[{pidx_q[8:6], pidx_q[2:0]}];
      end
      S_QSET: begin
        mul_a = {{(ROW_W-7){1'b0}}, Q_TABLE[zz_pos]};
        mul_b = {2'b00, scale_q};
      end
      default: begin
        mul_a = ROW_W'(sdat_q);
        mul_b = COS_MAT[{pidx_q[5:3], pidx_q[2:0]}];
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Halve the DC term toward zero: add one before the shift when negative
  assign num     = {ddat_q, 4'b0000};
  assign dc_val  = (ddat_q + $signed({{(DCT_W-1){1'b0}}, ddat_q[DCT_W-1]})) >>> 1;
  assign rem_sh  = {rem_q[REM_W-2:0], quo_q[NUM_W-1]};
  assign quo_nx  = {quo_q[NUM_W-2:0], (rem_sh >= {1'b0, div_q})};
  assign short_b = coef_q[7:0] + {run_q[3:0], 4'h0} + 8'd8;
  assign t16     = coef_q + 16'sd256;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    scnt_d   = scnt_q;
    cnt_d    = cnt_q;
    pvld_d   = 1'b0;
    acc_d    = acc_q;
    k_d      = k_q;
    run_d    = run_q;
    sym_d    = sym_q;
    bcnt_d   = bcnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    div_d    = div_q;
    neg_d    = neg_q;
    coef_d   = coef_q;
    ovld_d   = ovld_q && !out_s.ready;
    oword_d  = oword_q;
    obytes_d = obytes_q;
    olast_d  = olast_q;
    ocount_d = ocount_q;
    if (pvld_q) begin
      acc_d = ((pidx_q[2:0] == 3'd0) ? '0 : acc_q) + ACC_W'(prod);
    end
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          scnt_d = scnt_q + 6'd1;
          if (in_s.last_sample) begin
            scnt_d  = '0;
            cnt_d   = '0;
            state_d = S_ROW;
          end
        end
      end
      S_ROW, S_COL: begin
        if (!cnt_q[9]) begin
          pvld_d = 1'b1;
          cnt_d  = cnt_q + 10'd1;
        end
        if (pvld_q && (pidx_q == 9'd511)) begin
          cnt_d   = '0;
          pvld_d  = 1'b0;
          k_d     = '0;
          run_d   = '0;
          sym_d   = 6'd1;
          state_d = (state_q == S_ROW) ? S_COL : S_QRD;
        end
      end
      S_QRD: begin
        state_d = S_QSET;
      end
      S_QSET: begin
        neg_d  = num[NUM_W-1];
        quo_d  = num[NUM_W-1] ? NUM_W'(-num) : num;
        rem_d  = '0;
        div_d  = {prod[DIV_W-2:0], 1'b0};
        bcnt_d = '0;
        if (k_q == 6'd0) begin
          coef_d  = CODE_W'(dc_val);
          state_d = S_QEMIT;
        end else begin
          state_d = S_QDIV;
        end
      end
      S_QDIV: begin
        rem_d  = (rem_sh >= {1'b0, div_q}) ? rem_sh - {1'b0, div_q} : rem_sh;
        quo_d  = quo_nx;
        bcnt_d = bcnt_q + 4'd1;
        if (bcnt_q == 4'd15) begin
          if (scale_q == '0) begin
            coef_d = '0;
          end else begin
            coef_d = neg_q ? -quo_nx : quo_nx;
          end
          state_d = S_QEMIT;
        end
      end
      S_QEMIT: begin
        if (k_q != 6'd0 && coef_q == '0) begin
          run_d = run_q + 6'd1;
          k_d   = k_q + 6'd1;
          state_d = (k_q == 6'(LAST_CODED - 1)) ? S_END : S_QRD;
        end else if (can_load) begin
          ovld_d   = 1'b1;
          olast_d  = 1'b0;
          ocount_d = '0;
          if (k_q == 6'd0) begin
            oword_d  = {scale_q, coef_q[9:0]};
            obytes_d = TWO_BYTES;
          end else begin
            if (run_q < 6'd7 && coef_q < 16'sd7 && coef_q >= -16'sd8) begin
              oword_d  = {8'h00, short_b};
              obytes_d = ONE_BYTE;
            end else begin
              oword_d  = LONG_MARK | {1'b0, run_q, (t16[15] ? 9'd0 : t16[8:0])};
              obytes_d = TWO_BYTES;
            end
            run_d = '0;
            sym_d = sym_q + 6'd1;
          end
          k_d     = k_q + 6'd1;
          state_d = (k_q == 6'(LAST_CODED - 1)) ? S_END : S_QRD;
        end
      end
      S_END: begin
        if (can_load) begin
          ovld_d   = 1'b1;
          oword_d  = END_CODE;
          obytes_d = ONE_BYTE;
          olast_d  = 1'b1;
          ocount_d = sym_q + 6'd1;
          state_d  = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      scnt_q  <= '0;
      cnt_q   <= '0;
      pvld_q  <= 1'b0;
      k_q     <= '0;
      run_q   <= '0;
      sym_q   <= '0;
      bcnt_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      scnt_q  <= scnt_d;
      cnt_q   <= cnt_d;
      pvld_q  <= pvld_d;
      k_q     <= k_d;
      run_q   <= run_d;
      sym_q   <= sym_d;
      bcnt_q  <= bcnt_d;
      ovld_q  <= ovld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pidx_q   <= cnt_q[8:0];
    acc_q    <= acc_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    div_q    <= div_d;
    neg_q    <= neg_d;
    coef_q   <= coef_d;
    oword_q  <= oword_d;
    obytes_q <= obytes_d;
    olast_q  <= olast_d;
    ocount_q <= ocount_d;
  end

  // Sample store
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smem[scnt_q] <= in_s.sample;
    end
    sdat_q <= smem[{cnt_q[8:6], cnt_q[2:0]}];
  end

  // Row pass store
  always_ff @(posedge clk_i) begin
    if (state_q == S_ROW && pvld_q && pidx_q[2:0] == 3'd7) begin
      rmem[pidx_q[8:3]] <= acc_d[ROW_W-1:0];
    end
    rdat_q <= rmem[{cnt_q[2:0], cnt_q[5:3]}];
  end

  // Transform result store
  always_ff @(posedge clk_i) begin
    if (state_q == S_COL && pvld_q && pidx_q[2:0] == 3'd7) begin
      dmem[pidx_q[8:3]] <= acc_d[DCT_SHIFT+DCT_W-1:DCT_SHIFT];
    end
    ddat_q <= dmem[zz_pos];
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 8x8 DCT / quantize / run-length block encoder.
// Blocks of samples go in on the sample channel while a local predictor
// computes the code words. The code channel is checked field by field
// against them. Both sides idle at random. One long receiver hold-off stalls
// the encoder. The quantizer scale is changed between phases over the
// register port.
// ----------------------------------------------------------------------------
module tb;
  import dqr_pkg::*;

  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned HOLD_CYCLES = 3000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] word;
    logic [1:0]        bytes;
    logic              last;
    logic [5:0]        count;
  } code_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dqr_in_if  in_c ();
  dqr_out_if out_c ();

  dct_quant_rle_block_encoder_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_s    (in_c),
    .out_s   (out_c),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  sample_item_t pending_samples[$];
  code_item_t   expected_codes[$];
  int           mismatches = 0;
  bit           calm = 1'b0;
  int           hold_cnt = 0;
  bit           hold_done = 1'b0;
  int           codes_seen = 0;
  int           idle_cnt = 0;

  // Predictor state
  logic [5:0] pred_scale = 6'(SCALE_RESET);
  int         pix[64];
  int         rowp[64];
  int         coef[64];
  int         pix_ptr = 0;

  function automatic int signed_cos(int r, int c);
    return int'(COS_MAT[r*8+c]);
  endfunction

  // Transform, quantize and code the stored block into expected words
  function automatic void encode_stored_block();
    int dct[64];
    int acc, dv, run, lvl, idx, symbols;
    logic [31:0] w;
    code_item_t ci;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        acc = 0;
        for (int k = 0; k < 8; k++) acc += pix[r*8+k] * signed_cos(c, k);
        rowp[r*8+c] = acc;
      end
    end
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        acc = 0;
        for (int k = 0; k < 8; k++) acc += signed_cos(r, k) * rowp[k*8+c];
        dct[r*8+c] = acc >>> DCT_SHIFT;
      end
    end
    coef[0] = dct[0] / 2;
    for (int k = 1; k < 64; k++) begin
      dv = int'(Q_TABLE[ZZ_ORDER[k]]) * 2 * int'(pred_scale);
      coef[k] = (dv == 0) ? 0 : (dct[ZZ_ORDER[k]] * 16) / dv;
    end
    ci.word = {pred_scale, 10'(coef[0])};
    ci.bytes = TWO_BYTES;
    ci.last = 1'b0;
    ci.count = '0;
    expected_codes.push_back(ci);
    idx = 1;
    symbols = 1;
    while (idx < LAST_CODED) begin
      run = 0;
      while (idx < LAST_CODED && coef[idx] == 0) begin
        run++;
        idx++;
      end
      if (idx == LAST_CODED) break;
      lvl = coef[idx];
      if (run < 7 && lvl < 7 && lvl >= -8) begin
        w = 32'(lvl + run * 16 + 8) & 32'hFF;
        ci.bytes = ONE_BYTE;
      end else begin
        w = 32'(lvl + 256) & 32'hFFFF;
        if (w[15]) w = 0;
        w = (32'(run) << 9) | 32'(LONG_MARK) | (w & 32'h1FF);
        ci.bytes = TWO_BYTES;
      end
      ci.word = w[15:0];
      expected_codes.push_back(ci);
      idx++;
      symbols++;
    end
    ci.word = END_CODE;
    ci.bytes = ONE_BYTE;
    ci.last = 1'b1;
    ci.count = 6'(symbols + 1);
    expected_codes.push_back(ci);
  endfunction

  // Sample driver: advance on acceptance, idle at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_c.valid <= 1'b0;
      in_c.sample <= '0;
      in_c.last_sample <= 1'b0;
    end else begin
      if (in_c.valid && in_c.ready) begin
        pix[pix_ptr] = int'(in_c.sample);
        pix_ptr = (pix_ptr + 1) % 64;
        if (in_c.last_sample) begin
          pix_ptr = 0;
          encode_stored_block();
        end
      end
      if (!in_c.valid || in_c.ready) begin
        if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
          in_c.valid <= 1'b1;
          in_c.sample <= pending_samples[0].sample;
          in_c.last_sample <= pending_samples[0].last;
          void'(pending_samples.pop_front());
        end else begin
          in_c.valid <= 1'b0;
        end
      end
    end
  end

  // Code receiver: stall at random, hold off once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_c.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_c.ready <= 1'b0;
    end else if (!hold_done && codes_seen >= 1) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_c.ready <= 1'b0;
    end else begin
      out_c.ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  // Code monitor: compare against the oldest expected word
  always @(posedge clk_i) begin
    code_item_t want;
    if (rst_ni && out_c.valid && out_c.ready) begin
      codes_seen <= codes_seen + 1;
      if (expected_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected code word %h bytes %0d", out_c.code_word, out_c.code_bytes);
      end else begin
        want = expected_codes.pop_front();
        if (out_c.code_word !== want.word || out_c.code_bytes !== want.bytes ||
            out_c.last_code !== want.last ||
            out_c.symbol_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                     want.word, want.bytes, want.last, want.count,
                     out_c.code_word, out_c.code_bytes, out_c.last_code,
                     out_c.symbol_count);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_c.valid && in_c.ready) || (out_c.valid && out_c.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'd0) pred_scale = data[5:0];
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || expected_codes.size() > 0 || in_c.valid)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  // Push a block of n samples; amp 128 gives the full sample range
  task automatic push_block(input int n, input int amp, input int fixed_mode);
    sample_item_t it;
    for (int i = 0; i < n; i++) begin
      case (fixed_mode)
        1: it.sample = -8'sd128;
        2: it.sample = 8'sd127;
        3: it.sample = (((i >> 3) + i) % 2) ? 8'sd127 : -8'sd128;
        default: begin
          if (amp >= 128) it.sample = 8'($urandom);
          else it.sample = 8'($urandom_range(2 * amp) - amp);
        end
      endcase
      it.last = (i == n - 1);
      pending_samples.push_back(it);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Extreme block at reset scale, then a long block that wraps the counter
    push_block(64, 0, 1);
    push_block(70, 128, 0);
    drain();
    // Zero scale forces every AC level to zero
    reg_write(3'd0, 32'd0);
    push_block(12, 40, 0);
    drain();
    // Upper data bits and the unused index are ignored
    reg_write(3'd0, 32'hFFFF_FFC1);
    reg_write(3'd4, 32'd17);
    calm = 1'b1;
    push_block(64, 0, 3);
    drain();
    calm = 1'b0;
    // Largest scale on a short block
    reg_write(3'd0, 32'd63);
    push_block(10, 128, 0);
    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dqr_pkg.sv
rtl/dqr_if.sv
rtl/dct_quant_rle_block_encoder_core.sv
sim/tb.sv
